// ----- rtl/core/x10m_pkg.sv -----
// Shared types, codes and sizes of the meter frame transmitter.
package x10m_pkg;

    localparam int unsigned FRAME_W   = 48;
    localparam int unsigned BITPOS_W  = 6;
    localparam int unsigned DUR_W     = 16;
    localparam int unsigned TICK_W    = DUR_W + 1;
    localparam int unsigned REP_W     = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_AW      = 1;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_START_HI = 3'd1;
    localparam logic [2:0] PH_START_LO = 3'd2;
    localparam logic [2:0] PH_BIT_HI   = 3'd3;
    localparam logic [2:0] PH_BIT_LO   = 3'd4;
    localparam logic [2:0] PH_STOP_HI  = 3'd5;
    localparam logic [2:0] PH_STOP_LO  = 3'd6;
    localparam logic [2:0] PH_GAP      = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SHORT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LONG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LED        = 3'd6;

    localparam logic [7:0] KIND_COUNT0   = 8'h00;
    localparam logic [7:0] KIND_INTERVAL = 8'h01;
    localparam logic [7:0] KIND_COUNT2   = 8'h02;
    localparam logic [7:0] KIND_EMPTY3   = 8'h03;
    localparam logic [7:0] KIND_EMPTY4   = 8'h04;
    localparam logic [7:0] KIND_COUNT11  = 8'h0B;
    localparam logic [7:0] KIND_EMPTY12  = 8'h0C;
    localparam logic [7:0] KIND_EMPTY13  = 8'h0D;
    localparam logic [7:0] KIND_EMPTY14  = 8'h0E;
    localparam logic [7:0] KIND_ADDR_IVL = 8'h0F;

    localparam logic [7:0]  IVL_DEFAULT = 8'h01;
    localparam logic [23:0] COUNT_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic [DUR_W-1:0] start_high;
        logic [DUR_W-1:0] start_low;
        logic [DUR_W-1:0] bit_short;
        logic [DUR_W-1:0] bit_long;
        logic [DUR_W-1:0] gap;
        logic [REP_W-1:0] repeat_count;
        logic             led_enable;
    } t_cfg;

    typedef struct packed {
        logic               send;
        logic [FRAME_W-1:0] frame;
    } t_cmd_beat;

    typedef struct packed {
        logic tx_level;
        logic led_level;
        logic busy_res;
        logic send_accepted;
    } t_result;

    typedef struct packed {
        logic                sending;
        logic [2:0]          phase;
        logic [REP_W-1:0]    reps;
        logic [BITPOS_W-1:0] bitpos;
        logic [TICK_W-1:0]   ticks;
    } t_line;

endpackage

// ----- rtl/core/x10m_front.sv -----
// Front end: frame assembly and the command queue toward the line sequencer.
module x10m_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_cmd,
    input  logic [7:0]           i_meter_address,
    input  logic [7:0]           i_packet_kind,
    input  logic signed [31:0]   i_meter_value,
    input  logic                 i_take,
    output logic                 o_avail,
    output x10m_pkg::t_cmd_beat  o_beat
);
    import x10m_pkg::*;

    t_cmd_beat        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [Q_AW:0]    r_cnt, n_cnt;

    logic [31:0] uv;
    logic [7:0]  code;
    logic [7:0]  b0, b1, b2, b3, b4, b5;
    logic [3:0]  typ, psum;
    logic        wr;
    t_cmd_beat   beat_in;

    always_comb begin
        uv = i_meter_value;
        if (!i_meter_value[31] && (i_meter_value[30:0] > 31'(COUNT_MAX))) begin
            uv = '0;
        end
        code = ((uv[31:8] == 24'd0) && $onehot(uv[7:0])) ? uv[7:0] : IVL_DEFAULT;
        b0 = i_meter_address;
        b1 = {~i_meter_address[7:4], i_meter_address[3:0]};
        b2 = '0;
        b3 = '0;
        b4 = '0;
        typ = i_packet_kind[3:0];
        case (i_packet_kind) inside
            KIND_INTERVAL: begin
                b2 = code;
            end
            KIND_ADDR_IVL: begin
                b2 = i_meter_address;
                b3 = code;
            end
            KIND_EMPTY3, KIND_EMPTY4, KIND_EMPTY12, KIND_EMPTY13, KIND_EMPTY14: begin
            end
            KIND_COUNT0, KIND_COUNT2, KIND_COUNT11: begin
                b4 = uv[23:16];
                b2 = uv[15:8];
                b3 = uv[7:0];
            end
            default: begin
                typ = 4'd0;
                b4 = uv[23:16];
                b2 = uv[15:8];
                b3 = uv[7:0];
            end
        endcase
        psum = typ + b0[7:4] + b0[3:0] + b1[7:4] + b1[3:0] + b2[7:4] + b2[3:0]
             + b3[7:4] + b3[3:0] + b4[7:4] + b4[3:0];
        b5 = {typ, ~psum};
        beat_in.send  = i_cmd;
        beat_in.frame = {b0, b1, b2, b3, b4, b5};
    end

    assign full    = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_beat  = r_mem[r_rp];
    assign wr      = push && !full;

    always_comb begin
        n_wp  = wr ? r_wp + Q_AW'(1) : r_wp;
        n_rp  = i_take ? r_rp + Q_AW'(1) : r_rp;
        n_cnt = r_cnt + (Q_AW + 1)'(wr) - (Q_AW + 1)'(i_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= beat_in;
        end
    end

endmodule

// ----- rtl/core/x10m_back.sv -----
// Back end: pulse-distance line sequencer, one beat or one skipped phase per cycle while the result queue is not full.
module x10m_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  x10m_pkg::t_cfg      i_cfg,
    input  logic                i_avail,
    input  x10m_pkg::t_cmd_beat i_beat,
    output logic                o_take,
    input  logic                i_out_full,
    output logic                o_push,
    output x10m_pkg::t_result   o_result
);
    import x10m_pkg::*;

    t_line              r_line, n_line;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_skip, n_skip;
    logic               r_acc, n_acc;

    t_line st, adv, res_line;
    logic  res_acc;

    function automatic t_line advance(t_line s, t_cfg c, logic [FRAME_W-1:0] f);
        t_line               n;
        logic [BITPOS_W-1:0] sh;
        logic [BITPOS_W-1:0] nb;
        logic                bitv;
        n    = s;
        sh   = BITPOS_W'(FRAME_W - 1) - s.bitpos;
        nb   = s.bitpos + BITPOS_W'(1);
        bitv = (s.bitpos < BITPOS_W'(FRAME_W)) ? f[sh] : 1'b0;
        unique case (s.phase)
            PH_START_HI: begin
                n.phase = PH_START_LO;
                n.ticks = TICK_W'(c.start_low);
            end
            PH_START_LO: begin
                n.phase  = PH_BIT_HI;
                n.bitpos = '0;
                n.ticks  = TICK_W'(c.bit_short);
            end
            PH_BIT_HI: begin
                n.phase = PH_BIT_LO;
                n.ticks = TICK_W'(c.bit_short) + (bitv ? TICK_W'(c.bit_long) : '0);
            end
            PH_BIT_LO: begin
                n.bitpos = nb;
                n.phase  = (nb < BITPOS_W'(FRAME_W)) ? PH_BIT_HI : PH_STOP_HI;
                n.ticks  = TICK_W'(c.bit_short);
            end
            PH_STOP_HI: begin
                n.phase = PH_STOP_LO;
                n.ticks = TICK_W'(c.bit_short) + TICK_W'(c.bit_long);
            end
            PH_STOP_LO: begin
                n.phase = PH_GAP;
                n.ticks = TICK_W'(c.gap);
            end
            PH_GAP: begin
                n.reps = s.reps - REP_W'(1);
                if (n.reps != '0) begin
                    n.phase = PH_START_HI;
                    n.ticks = TICK_W'(c.start_high);
                end else begin
                    n.phase   = PH_IDLE;
                    n.ticks   = '0;
                    n.sending = 1'b0;
                    n.bitpos  = '0;
                end
            end
            default: begin
                n.phase   = PH_IDLE;
                n.ticks   = '0;
                n.sending = 1'b0;
            end
        endcase
        return n;
    endfunction

    always_comb begin
        o_take   = 1'b0;
        o_push   = 1'b0;
        n_line   = r_line;
        n_frame  = r_frame;
        n_skip   = r_skip;
        n_acc    = r_acc;
        st       = r_line;
        adv      = advance(r_line, i_cfg, r_frame);
        res_line = r_line;
        res_acc  = r_acc;
        if (!i_out_full) begin
            if (r_skip) begin
                n_line   = adv;
                res_line = adv;
                if (!(adv.sending && (adv.ticks == '0))) begin
                    o_push = 1'b1;
                    n_skip = 1'b0;
                end
            end else if (i_avail) begin
                o_take  = 1'b1;
                res_acc = 1'b0;
                if (i_beat.send) begin
                    if (!st.sending) begin
                        res_acc   = 1'b1;
                        n_frame   = i_beat.frame;
                        st.bitpos = '0;
                        if (i_cfg.repeat_count != '0) begin
                            st.reps    = i_cfg.repeat_count;
                            st.sending = 1'b1;
                            st.phase   = PH_START_HI;
                            st.ticks   = TICK_W'(i_cfg.start_high);
                        end
                    end
                end else if (st.sending && (st.ticks != '0)) begin
                    st.ticks = st.ticks - TICK_W'(1);
                end
                n_line   = st;
                n_acc    = res_acc;
                res_line = st;
                if (st.sending && (st.ticks == '0)) begin
                    n_skip = 1'b1;
                end else begin
                    o_push = 1'b1;
                end
            end
        end
        o_result.tx_level = res_line.sending && ((res_line.phase == PH_START_HI)
                          || (res_line.phase == PH_BIT_HI) || (res_line.phase == PH_STOP_HI));
        o_result.led_level     = res_line.sending && i_cfg.led_enable;
        o_result.busy_res      = res_line.sending;
        o_result.send_accepted = res_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '{sending: 1'b0, phase: PH_IDLE, reps: '0, bitpos: '0, ticks: '0};
            r_frame <= '0;
            r_skip  <= 1'b0;
            r_acc   <= 1'b0;
        end else begin
            r_line  <= n_line;
            r_frame <= n_frame;
            r_skip  <= n_skip;
            r_acc   <= n_acc;
        end
    end

endmodule

// ----- rtl/core/x10m_outq.sv -----
// Result queue between the line sequencer and the result port.
module x10m_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  x10m_pkg::t_result i_result,
    output logic              o_full,
    input  logic              pop,
    output logic              empty,
    output x10m_pkg::t_result o_result
);
    import x10m_pkg::*;

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt;
    logic             rd, wr;

    assign o_full   = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign empty    = (r_cnt == '0);
    assign o_result = r_mem[r_rp];
    assign wr       = i_push && !o_full;
    assign rd       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW + 1)'(wr) - (Q_AW + 1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_result;
        end
    end

endmodule

// ----- rtl/core/x10_rf_meter_frame_transmitter.sv -----
// Top level of the meter frame transmitter: registers, front, sequencer and result queue.
//
// Each beat is either a timing tick or a send request; the block returns one result
// beat per input beat, showing the line and lamp levels after that beat. A 2-deep
// command queue feeds the sequencer and a 2-deep result queue decouples the pop side,
// so a beat is taken every cycle while the result side keeps up. The exception is a
// beat that ends a line phase: the sequencer then steps through each phase that
// follows, up to the first phase of nonzero duration or idle, and takes no beat
// meanwhile. With zero durations this can run through every phase of each remaining
// repeat, 15 repeats at most. Registers are written through the configuration
// channel, which is always ready; the user must write them only while no send is in
// progress, and the block itself does not enforce it.
module x10_rf_meter_frame_transmitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [x10m_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [x10m_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_cmd,
    input  logic [7:0]                      i_meter_address,
    input  logic [7:0]                      i_packet_kind,
    input  logic signed [31:0]              i_meter_value,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_tx_level,
    output logic                            o_led_level,
    output logic                            o_busy_res,
    output logic                            o_send_accepted
);
    import x10m_pkg::*;

    t_cfg      r_cfg;
    t_cmd_beat beat;
    t_result   back_res, head_res;
    logic      cmd_avail, cmd_take, res_push, res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_high   <= 16'd9000;
            r_cfg.start_low    <= 16'd4500;
            r_cfg.bit_short    <= 16'd560;
            r_cfg.bit_long     <= 16'd1120;
            r_cfg.gap          <= 16'd40000;
            r_cfg.repeat_count <= 4'd1;
            r_cfg.led_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_HIGH: r_cfg.start_high   <= i_cfg_data;
                CFG_START_LOW:  r_cfg.start_low    <= i_cfg_data;
                CFG_BIT_SHORT:  r_cfg.bit_short    <= i_cfg_data;
                CFG_BIT_LONG:   r_cfg.bit_long     <= i_cfg_data;
                CFG_GAP:        r_cfg.gap          <= i_cfg_data;
                CFG_REPEAT:     r_cfg.repeat_count <= i_cfg_data[REP_W-1:0];
                CFG_LED:        r_cfg.led_enable   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    x10m_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_meter_address (i_meter_address),
        .i_packet_kind   (i_packet_kind),
        .i_meter_value   (i_meter_value),
        .i_take          (cmd_take),
        .o_avail         (cmd_avail),
        .o_beat          (beat)
    );

    x10m_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_avail    (cmd_avail),
        .i_beat     (beat),
        .o_take     (cmd_take),
        .i_out_full (res_full),
        .o_push     (res_push),
        .o_result   (back_res)
    );

    x10m_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_result (back_res),
        .o_full   (res_full),
        .pop      (pop),
        .empty    (empty),
        .o_result (head_res)
    );

    assign o_tx_level      = head_res.tx_level;
    assign o_led_level     = head_res.led_level;
    assign o_busy_res      = head_res.busy_res;
    assign o_send_accepted = head_res.send_accepted;

    a_idle_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_busy_res) |-> !o_tx_level)
        else $error("line high while not sending");

    a_lamp_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_led_level) |-> o_busy_res)
        else $error("lamp on while not sending");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not cleared by reset");

endmodule
